### src/frt_pkg.sv
package frt_pkg;
	localparam int NUM_SLOTS_DEF = 8;
	localparam int MAX_MESSAGE_DEF = 2048;

	typedef enum logic [1:0] {
		OP_FEED = 2'd0,
		OP_RELEASE = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_PENDING = 2'd0,
		ST_COMPLETE = 2'd1,
		ST_ERROR = 2'd2,
		ST_READ = 2'd3
	} status_t;

	// classified beat handed from front to back
	typedef struct packed {
		op_t op;
		logic [15:0] class_key;
		logic [31:0] sequence_key;
		logic [15:0] message_len;
		logic [15:0] frag_offset;
		logic [15:0] frag_bytes;
		logic [15:0] byte_pos;
		logic [7:0] data_byte;
		logic last_of_fragment;
		logic [2:0] slot_select;
		logic first;
		logic len_bad;
		logic wr_in_frag;
		logic [16:0] wr_addr;
	} beat_t;
endpackage

### src/frt_front.sv
module frt_front import frt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] operation,
	input logic [15:0] class_key,
	input logic [31:0] sequence_key,
	input logic [15:0] message_len,
	input logic [15:0] frag_offset,
	input logic [15:0] frag_bytes,
	input logic [15:0] byte_pos,
	input logic [7:0] data_byte,
	input logic last_of_fragment,
	input logic [2:0] slot_select,
	output logic q_valid,
	output beat_t q_beat,
	input logic q_pop
);
	localparam int DEPTH = 2;

	beat_t fifo_q [DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	beat_t b;
	logic push;

	always_comb begin
		b.op = op_t'(operation);
		b.class_key = class_key;
		b.sequence_key = sequence_key;
		b.message_len = message_len;
		b.frag_offset = frag_offset;
		b.frag_bytes = frag_bytes;
		b.byte_pos = byte_pos;
		b.data_byte = data_byte;
		b.last_of_fragment = last_of_fragment;
		b.slot_select = slot_select;
		b.first = (byte_pos == 16'd0);
		b.len_bad = ({1'b0, frag_offset} + {1'b0, frag_bytes}) > {1'b0, message_len};
		b.wr_in_frag = byte_pos < frag_bytes;
		b.wr_addr = {1'b0, frag_offset} + {1'b0, byte_pos};
	end

	assign busy = (cnt_q == 2'(DEPTH));
	assign push = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_beat = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

### src/frt_back.sv
module frt_back import frt_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input beat_t q_beat,
	output logic q_pop,
	output logic result_valid,
	output logic [1:0] status,
	output logic [2:0] result_slot,
	output logic [11:0] assembled_len,
	output logic [7:0] read_data
);
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int AW = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;
	localparam int MW = SW + AW;
	localparam int TW = $clog2(MAX_MESSAGE + 1);

	logic [NUM_SLOTS-1:0] busy_q;
	logic [15:0] cls_q [NUM_SLOTS];
	logic [31:0] seq_q [NUM_SLOTS];
	logic [TW-1:0] tot_q [NUM_SLOTS];
	logic [31:0] rcv_q [NUM_SLOTS];
	logic [SW-1:0] cur_q;
	logic rej_q;
	logic [7:0] mem [2**MW];

	logic [NUM_SLOTS-1:0] hit;
	logic hit_any, free_any;
	logic [SW-1:0] hit_idx, free_idx, s_new, s_use;
	logic rej_new, rej_use, alloc;
	logic [TW-1:0] tot_use;
	logic [31:0] rcv_sum;
	logic wr_en;
	logic [MW-1:0] wr_a, rd_a;

	// read path: memory read and result registers share stage 1
	logic rd_s1, fd_s1;
	logic [1:0] st_s1;
	logic [2:0] slot_s1;
	logic [11:0] len_s1;
	logic rd_ok_s1;
	logic [7:0] rdat_s1;

	assign q_pop = q_valid;

	always_comb begin
		hit = '0;
		for (int i = 0; i < NUM_SLOTS; i++)
			hit[i] = busy_q[i] && cls_q[i] == q_beat.class_key
				&& seq_q[i] == q_beat.sequence_key;
		hit_any = |hit;
		hit_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--)
			if (hit[i]) hit_idx = SW'(i);
		free_any = ~&busy_q;
		free_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--)
			if (!busy_q[i]) free_idx = SW'(i);

		alloc = 1'b0;
		s_new = cur_q;
		rej_new = 1'b1;
		if (q_beat.message_len <= 16'(MAX_MESSAGE) || MAX_MESSAGE > 65535) begin
			if (!q_beat.len_bad) begin
				if (hit_any) begin
					s_new = hit_idx;
					rej_new = (tot_q[hit_idx] != '0)
						&& ({16'd0, tot_q[hit_idx]} != 32'(q_beat.message_len));
				end else if (free_any) begin
					s_new = free_idx;
					alloc = 1'b1;
					rej_new = 1'b0;
				end
			end
		end
		if (q_beat.op == OP_FEED && q_beat.first) begin
			s_use = s_new;
			rej_use = rej_new;
		end else begin
			s_use = cur_q;
			rej_use = rej_q;
		end
		if (32'(s_use) >= 32'(NUM_SLOTS)) s_use = '0;
		if (q_beat.op == OP_FEED && q_beat.first && (alloc || tot_q[s_use] == '0))
			tot_use = TW'(q_beat.message_len);
		else tot_use = tot_q[s_use];
		if (alloc) rcv_sum = 32'(q_beat.frag_bytes);
		else rcv_sum = rcv_q[s_use] + 32'(q_beat.frag_bytes);

		wr_en = q_valid && q_beat.op == OP_FEED && !rej_use && q_beat.wr_in_frag
			&& q_beat.wr_addr < 17'(MAX_MESSAGE);
		wr_a = {s_use, q_beat.wr_addr[AW-1:0]};
		rd_a = {q_beat.slot_select[SW-1:0], q_beat.frag_offset[AW-1:0]};
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_a] <= q_beat.data_byte;
		rdat_s1 <= mem[rd_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				cls_q[i] <= '0;
				seq_q[i] <= '0;
				tot_q[i] <= '0;
				rcv_q[i] <= '0;
			end
			cur_q <= '0;
			rej_q <= 1'b0;
			rd_s1 <= 1'b0;
			fd_s1 <= 1'b0;
			st_s1 <= ST_PENDING;
			slot_s1 <= '0;
			len_s1 <= '0;
			rd_ok_s1 <= 1'b0;
		end else begin
			rd_s1 <= q_valid && q_beat.op == OP_READ;
			fd_s1 <= q_valid && q_beat.op == OP_FEED && q_beat.last_of_fragment;
			if (q_valid) begin
				case (q_beat.op)
					OP_FEED: begin
						if (q_beat.first) begin
							rej_q <= rej_new;
							if (!(q_beat.message_len > 16'(MAX_MESSAGE) && MAX_MESSAGE <= 65535)
								&& !q_beat.len_bad && (hit_any || free_any)) begin
								cur_q <= s_new;
								if (alloc) begin
									busy_q[s_new] <= 1'b1;
									cls_q[s_new] <= q_beat.class_key;
									seq_q[s_new] <= q_beat.sequence_key;
									if (!q_beat.last_of_fragment) rcv_q[s_new] <= '0;
								end
								tot_q[s_new] <= tot_use;
							end
						end
						if (q_beat.last_of_fragment) begin
							if (rej_use) begin
								st_s1 <= ST_ERROR;
								slot_s1 <= '0;
								len_s1 <= '0;
							end else begin
								rcv_q[s_use] <= rcv_sum;
								st_s1 <= ({20'd0, tot_use} <= {20'd0, rcv_sum[TW-1:0]}
									&& (rcv_sum >> TW) == 0) || (rcv_sum >> TW) != 0
									? ST_COMPLETE : ST_PENDING;
								slot_s1 <= 3'(s_use);
								len_s1 <= 12'(tot_use);
							end
						end
					end
					OP_RELEASE: begin
						if (hit_any) busy_q[hit_idx] <= 1'b0;
					end
					OP_READ: begin
						st_s1 <= ST_READ;
						slot_s1 <= q_beat.slot_select;
						rd_ok_s1 <= 32'(q_beat.slot_select) < 32'(NUM_SLOTS)
							&& 32'(q_beat.frag_offset) < 32'(MAX_MESSAGE);
						if (32'(q_beat.slot_select) < 32'(NUM_SLOTS))
							len_s1 <= 12'(tot_q[q_beat.slot_select[SW-1:0]]);
						else
							len_s1 <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	assign result_valid = rd_s1 || fd_s1;
	assign status = st_s1;
	assign result_slot = slot_s1;
	assign assembled_len = len_s1;
	assign read_data = (rd_s1 && rd_ok_s1) ? rdat_s1 : 8'd0;
endmodule

### src/fragment_reassembly_table.sv
// an accepted beat is registered in the front queue, then its result in the back's stage-1 registers
// throughput: one beat per cycle while busy is low; a two-entry queue sits between front and back
// the back retires one beat every cycle, so busy only rises on a full queue
// results are strobed for one cycle on done; the receiver cannot stall
// arst_n clears slot table, queue and strobe; payload memory is not cleared
module fragment_reassembly_table import frt_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] operation,
	input logic [15:0] class_key,
	input logic [31:0] sequence_key,
	input logic [15:0] message_len,
	input logic [15:0] frag_offset,
	input logic [15:0] frag_bytes,
	input logic [15:0] byte_pos,
	input logic [7:0] data_byte,
	input logic last_of_fragment,
	input logic [2:0] slot_select,
	output logic done,
	output logic [1:0] status,
	output logic [2:0] result_slot,
	output logic [11:0] assembled_len,
	output logic [7:0] read_data
);
	logic q_valid, q_pop;
	beat_t q_beat;

	frt_front u_front (
		.clk, .arst_n, .start, .busy, .operation, .class_key, .sequence_key,
		.message_len, .frag_offset, .frag_bytes, .byte_pos, .data_byte,
		.last_of_fragment, .slot_select, .q_valid, .q_beat, .q_pop
	);

	frt_back #(.NUM_SLOTS(NUM_SLOTS), .MAX_MESSAGE(MAX_MESSAGE)) u_back (
		.clk, .arst_n, .q_valid, .q_beat, .q_pop, .result_valid(done),
		.status, .result_slot, .assembled_len, .read_data
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_ERROR |-> result_slot == 3'd0 && assembled_len == 12'd0)
		else $error("error result carries data");
	a_read_data: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_READ |-> read_data == 8'd0)
		else $error("feed result carries read data");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");
endmodule
